FILE: hw/rtl/gouy_chapman_surface_activity_macros.svh
// assertion macros for the gouy-chapman surface activity block
`ifndef GOUY_CHAPMAN_SURFACE_ACTIVITY_MACROS_SVH
`define GOUY_CHAPMAN_SURFACE_ACTIVITY_MACROS_SVH
`ifndef SYNTHESIS
`define GCSA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GCSA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GCSA_ASSERT_IMP(label, ante, cons, msg)
`define GCSA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/gcsa_pkg.sv
// types and constants shared by the surface activity block
package gcsa_pkg;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef enum logic [2:0] {
        REG_POS_IDX,
        REG_NEU_IDX,
        REG_NEG_IDX,
        REG_PROTON_IDX,
        REG_CHARGED_MASK,
        REG_CHARGE_SCALE,
        REG_ION_FLOOR,
        REG_SITE_EPS
    } cfg_reg_t;

    // request to the serial arithmetic unit
    typedef struct packed {
        logic      start;
        arith_op_t op;
        logic [63:0] a;
        logic [63:0] b;
    } arith_req_t;

    localparam int unsigned DIV_STEPS  = 64;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned MUL_STEPS  = 34;

endpackage

FILE: hw/rtl/gcsa_arith.sv
// bit-serial multiply, divide and square root unit
module gcsa_arith (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gcsa_pkg::arith_req_t   req,
    output logic                   done,
    output logic [67:0]            res
);
    import gcsa_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    arith_op_t   op_reg;
    logic [67:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] src_reg, src_next;
    logic [63:0] dvs_reg;

    logic [67:0] div_t, sqrt_t, sqrt_trial;
    logic [34:0] mul_sum;

    always_comb
    begin
        div_t      = {rem_reg[66:0], src_reg[63]};
        sqrt_t     = {rem_reg[65:0], src_reg[63:62]};
        sqrt_trial = {2'b00, quo_reg, 2'b01};
        mul_sum    = {1'b0, rem_reg[67:34]}
                   + (rem_reg[0] ? {1'b0, dvs_reg[33:0]} : 35'd0);
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        src_next   = src_reg;
        case (op_reg)
            OP_DIV:
            begin
                src_next = {src_reg[62:0], 1'b0};
                if (div_t >= {4'b0, dvs_reg})
                begin
                    rem_next = div_t - {4'b0, dvs_reg};
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = div_t;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end
            OP_SQRT:
            begin
                src_next = {src_reg[61:0], 2'b00};
                if (sqrt_t >= sqrt_trial)
                begin
                    rem_next = sqrt_t - sqrt_trial;
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = sqrt_t;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end
            default:
            begin
                rem_next = {mul_sum, rem_reg[33:1]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                unique case (req.op)
                    OP_DIV:  cnt_reg <= 7'(DIV_STEPS - 1);
                    OP_SQRT: cnt_reg <= 7'(SQRT_STEPS - 1);
                    default: cnt_reg <= 7'(MUL_STEPS - 1);
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            src_reg <= req.a;
            dvs_reg <= (req.op == OP_MUL) ? req.a : req.b;
            quo_reg <= '0;
            rem_reg <= (req.op == OP_MUL) ? {34'b0, req.b[33:0]} : 68'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            src_reg <= src_next;
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == OP_MUL) ? rem_reg : {4'b0, quo_reg};

endmodule

FILE: hw/rtl/gouy_chapman_surface_activity.sv
// gouy-chapman surface proton activity: top level with sequencer
// a component without the last flag is taken while idle; a last component
// starts the cell calculation on the shared one-bit-per-cycle
// arithmetic unit (up to three divides of 64 steps, two roots of 32, four multiplies of 34)
// throughput: one component per cycle within a cell, one result per cell
// reset: registers take their documented values, sums and latches clear to zero
module gouy_chapman_surface_activity #(
    parameter int NUM_COMPONENTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // conc [31:0], comp_index [37:32], zero fill
    input  logic        s_axis_tlast,   // last component of the cell
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // surface_activity [31:0], factor [63:32]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data
);
    import gcsa_pkg::*;

    `include "gouy_chapman_surface_activity_macros.svh"

    localparam logic [6:0] IDX_LIMIT = 7'(NUM_COMPONENTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RION,   // root of the ion strength
        S_Q,      // charge ratio
        S_S,      // scaled charge
        S_X,      // x magnitude
        S_MSQ,    // x squared
        S_H,      // root of x*x+1
        S_G,      // reciprocal or sum
        S_F,      // factor
        S_ACT,    // factor times proton
        S_OUT
    } state_t;

    // configuration registers
    logic [5:0]  pos_idx_reg, neu_idx_reg, neg_idx_reg, proton_idx_reg;
    logic [63:0] charged_mask_reg;
    logic [31:0] charge_scale_reg, ion_floor_reg, site_eps_reg;

    // per-cell state
    logic [39:0] ion_sum_reg;
    logic [31:0] pos_reg, neu_reg, neg_reg, proton_reg;
    logic [40:0] ion_reg;

    // sequencer and intermediates
    state_t      state_reg;
    logic        started_reg;
    logic        sign_reg;
    logic [31:0] r_reg;
    logic [16:0] q_reg;
    logic [32:0] s_reg;
    logic [31:0] mag_reg;
    logic [63:0] sq_reg;
    logic [31:0] h_reg;
    logic [32:0] g_reg;
    logic [31:0] f_reg;
    logic [31:0] act_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;

    // input request fields
    logic [31:0] conc;
    logic [5:0]  comp;
    logic        in_acc;
    logic        in_range;
    logic [40:0] sum_wide;
    logic [39:0] ion_sum_sat;

    assign conc     = s_axis_tdata[31:0];
    assign comp     = s_axis_tdata[37:32];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_range = ({1'b0, comp} < IDX_LIMIT);

    // saturating ion sum including the current component
    always_comb
    begin
        sum_wide = {1'b0, ion_sum_reg};
        if (in_range && charged_mask_reg[comp])
        begin
            sum_wide = {1'b0, ion_sum_reg} + {9'b0, conc};
        end
        ion_sum_sat = sum_wide[40] ? '1 : sum_wide[39:0];
    end

    // cell arithmetic inputs
    logic [33:0] total;
    logic [31:0] diff;
    logic        neg_wins;
    logic [32:0] hm;
    logic        calc_state;
    arith_req_t  req;
    logic        ar_done;
    logic [67:0] ar_res;

    assign total    = {2'b0, pos_reg} + {2'b0, neu_reg} + {2'b0, neg_reg}
                    + {2'b0, site_eps_reg};
    assign neg_wins = neg_reg > pos_reg;
    assign diff     = neg_wins ? (neg_reg - pos_reg) : (pos_reg - neg_reg);
    assign hm       = {1'b0, h_reg} + {1'b0, mag_reg};

    assign calc_state = (state_reg == S_RION) || (state_reg == S_Q)
                     || (state_reg == S_S) || (state_reg == S_X)
                     || (state_reg == S_MSQ) || (state_reg == S_H)
                     || (state_reg == S_F) || (state_reg == S_ACT)
                     || ((state_reg == S_G) && !sign_reg);

    always_comb
    begin
        req.start = calc_state && !started_reg;
        req.op    = OP_MUL;
        req.a     = '0;
        req.b     = '0;
        case (state_reg)
            S_RION:
            begin
                req.op = OP_SQRT;
                req.a  = {7'b0, ion_reg, 16'b0};
            end
            S_Q:
            begin
                req.op = OP_DIV;
                req.a  = {16'b0, diff, 16'b0};
                req.b  = {30'b0, total};
            end
            S_S:
            begin
                req.a = {47'b0, q_reg};
                req.b = {32'b0, charge_scale_reg};
            end
            S_X:
            begin
                req.op = OP_DIV;
                req.a  = {15'b0, s_reg, 16'b0};
                req.b  = {32'b0, r_reg};
            end
            S_MSQ:
            begin
                req.a = {32'b0, mag_reg};
                req.b = {32'b0, mag_reg};
            end
            S_H:
            begin
                req.op = OP_SQRT;
                req.a  = sq_reg + 64'h1_0000_0000;
            end
            S_G:
            begin
                req.op = OP_DIV;
                req.a  = 64'h1_0000_0000;
                req.b  = {31'b0, hm};
            end
            S_F:
            begin
                req.a = {31'b0, g_reg};
                req.b = {31'b0, g_reg};
            end
            S_ACT:
            begin
                req.a = {32'b0, f_reg};
                req.b = {32'b0, proton_reg};
            end
            default:
            begin
                req.start = 1'b0;
            end
        endcase
    end

    gcsa_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .done  (ar_done),
        .res   (ar_res)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_idx_reg      <= 6'd0;
            neu_idx_reg      <= 6'd1;
            neg_idx_reg      <= 6'd2;
            proton_idx_reg   <= 6'd3;
            charged_mask_reg <= '0;
            charge_scale_reg <= 32'h0001_0000;
            ion_floor_reg    <= '0;
            site_eps_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_POS_IDX:      pos_idx_reg      <= cfg_data[5:0];
                REG_NEU_IDX:      neu_idx_reg      <= cfg_data[5:0];
                REG_NEG_IDX:      neg_idx_reg      <= cfg_data[5:0];
                REG_PROTON_IDX:   proton_idx_reg   <= cfg_data[5:0];
                REG_CHARGED_MASK: charged_mask_reg <= cfg_data;
                REG_CHARGE_SCALE: charge_scale_reg <= cfg_data[31:0];
                REG_ION_FLOOR:    ion_floor_reg    <= cfg_data[31:0];
                REG_SITE_EPS:     site_eps_reg     <= cfg_data[31:0];
            endcase
        end
    end

    // sequencer: accumulation while idle, then at most one serial operation per state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            sign_reg      <= 1'b0;
            ion_sum_reg   <= '0;
            pos_reg       <= '0;
            neu_reg       <= '0;
            neg_reg       <= '0;
            proton_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the output state reloads the slot itself
            if (out_valid_reg && m_axis_tready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ar_done)
            begin
                started_reg <= 1'b0;
            end
            else if (req.start)
            begin
                started_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        // shared indices let several latches take the same request
                        if (in_range && comp == pos_idx_reg)    pos_reg    <= conc;
                        if (in_range && comp == neu_idx_reg)    neu_reg    <= conc;
                        if (in_range && comp == neg_idx_reg)    neg_reg    <= conc;
                        if (in_range && comp == proton_idx_reg) proton_reg <= conc;
                        if (s_axis_tlast)
                        begin
                            ion_reg     <= {1'b0, ion_sum_sat} + {9'b0, ion_floor_reg};
                            ion_sum_reg <= '0;
                            state_reg   <= S_RION;
                        end
                        else
                        begin
                            ion_sum_reg <= ion_sum_sat;
                        end
                    end
                end
                S_RION:
                begin
                    if (ar_done)
                    begin
                        r_reg <= ar_res[31:0];
                        // zero site total or zero root gives x of zero
                        if (total == 34'd0 || ar_res[31:0] == 32'd0)
                        begin
                            mag_reg   <= '0;
                            sign_reg  <= 1'b0;
                            state_reg <= S_MSQ;
                        end
                        else
                        begin
                            sign_reg  <= neg_wins;
                            state_reg <= S_Q;
                        end
                    end
                end
                S_Q:
                begin
                    if (ar_done)
                    begin
                        q_reg     <= ar_res[16:0];
                        state_reg <= S_S;
                    end
                end
                S_S:
                begin
                    if (ar_done)
                    begin
                        s_reg     <= ar_res[48:16];
                        state_reg <= S_X;
                    end
                end
                S_X:
                begin
                    if (ar_done)
                    begin
                        mag_reg <= (ar_res[63:32] != 32'd0) ? '1 : ar_res[31:0];
                        if (ar_res[63:0] == 64'd0)
                        begin
                            sign_reg <= 1'b0;
                        end
                        state_reg <= S_MSQ;
                    end
                end
                S_MSQ:
                begin
                    if (ar_done)
                    begin
                        sq_reg    <= ar_res[63:0];
                        state_reg <= S_H;
                    end
                end
                S_H:
                begin
                    if (ar_done)
                    begin
                        h_reg     <= ar_res[31:0];
                        state_reg <= S_G;
                    end
                end
                S_G:
                begin
                    // negative x: sqrt(x*x+1)+|x|, otherwise its reciprocal
                    if (sign_reg)
                    begin
                        g_reg     <= hm;
                        state_reg <= S_F;
                    end
                    else if (ar_done)
                    begin
                        g_reg     <= ar_res[32:0];
                        state_reg <= S_F;
                    end
                end
                S_F:
                begin
                    if (ar_done)
                    begin
                        f_reg     <= (ar_res[67:48] != 20'd0) ? '1 : ar_res[47:16];
                        state_reg <= S_ACT;
                    end
                end
                S_ACT:
                begin
                    if (ar_done)
                    begin
                        act_reg   <= (ar_res[67:48] != 20'd0) ? '1 : ar_res[47:16];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // wait for the output slot to free up before loading it
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg  <= {f_reg, act_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `GCSA_ASSERT_IMP(a_done_started, ar_done, started_reg, "arith done without a request")
    `GCSA_ASSERT_NXT(a_last_busy, in_acc && s_axis_tlast, !s_axis_tready, "no busy after last")
    `GCSA_ASSERT_NXT(a_sum_clear, in_acc && s_axis_tlast, ion_sum_reg == 40'd0, "ion sum kept")
    `GCSA_ASSERT_IMP(a_out_from_seq, $rose(m_axis_tvalid), $past(state_reg == S_OUT), "stray result")

endmodule

FILE: bench/gcsa_checker.sv
// checker for the surface activity block: predicts each cell result and compares
module gcsa_checker #(
    parameter int NUM_COMPONENTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // conc [31:0], comp_index [37:32], zero fill
    input  logic        s_axis_tlast,   // last component of the cell
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // surface_activity [31:0], factor [63:32]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import gcsa_pkg::*;

    typedef struct packed {
        logic [31:0] factor;
        logic [31:0] activity;
    } cell_result_t;

    logic [5:0]  pos_idx, neu_idx, neg_idx, h_idx;
    logic [63:0] mask;
    logic [31:0] scale, floor_v, eps;
    logic [39:0] ion_acc;
    logic [31:0] pos_c, neu_c, neg_c, h_c;
    cell_result_t cell_q[$];

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] clip32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic cell_result_t surface_result();
        cell_result_t r;
        logic [63:0] total, diff, ion, rt, mag, q, s, h, g, f;
        logic        negative;
        total = 64'(pos_c) + neu_c + neg_c + eps;
        negative = neg_c > pos_c;
        diff = negative ? 64'(neg_c - pos_c) : 64'(pos_c - neg_c);
        ion = 64'(ion_acc) + floor_v;
        rt = root64(ion << 16);
        mag = 0;
        if (total != 0 && rt != 0)
        begin
            q = (diff << 16) / total;
            s = (q * scale) >> 16;
            mag = clip32((s << 16) / rt);
        end
        if (mag == 0)
            negative = 0;
        h = root64(mag * mag + (64'd1 << 32));
        g = negative ? h + mag : (64'd1 << 32) / (h + mag);
        if (g > 64'hFFFF_FFFF_FFFF)
            f = 64'hFFFF_FFFF;
        else if (g != 0 && g > (64'hFFFF_FFFF_FFFF_FFFF / g))
            f = 64'hFFFF_FFFF;
        else
            f = clip32((g * g) >> 16);
        r.activity = 32'(clip32((f * h_c) >> 16));
        r.factor = f[31:0];
        return r;
    endfunction

    assign pending = cell_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] c;
        logic [5:0]  ix;
        logic [40:0] acc;
        cell_result_t e;
        cell_result_t a;
        if (!rst_n)
        begin
            pos_idx <= 0; neu_idx <= 1; neg_idx <= 2; h_idx <= 3;
            mask <= 0; scale <= 32'h0001_0000; floor_v <= 0; eps <= 0;
            ion_acc <= 0; pos_c <= 0; neu_c <= 0; neg_c <= 0; h_c <= 0;
            cell_q.delete();
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_POS_IDX:      pos_idx = cfg_data[5:0];
                    REG_NEU_IDX:      neu_idx = cfg_data[5:0];
                    REG_NEG_IDX:      neg_idx = cfg_data[5:0];
                    REG_PROTON_IDX:   h_idx = cfg_data[5:0];
                    REG_CHARGED_MASK: mask = cfg_data;
                    REG_CHARGE_SCALE: scale = cfg_data[31:0];
                    REG_ION_FLOOR:    floor_v = cfg_data[31:0];
                    REG_SITE_EPS:     eps = cfg_data[31:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                c = s_axis_tdata[31:0];
                ix = s_axis_tdata[37:32];
                if (ix < NUM_COMPONENTS)
                begin
                    if (mask[ix])
                    begin
                        acc = 41'(ion_acc) + c;
                        ion_acc = acc[40] ? 40'hFF_FFFF_FFFF : acc[39:0];
                    end
                    if (ix == pos_idx) pos_c = c;
                    if (ix == neu_idx) neu_c = c;
                    if (ix == neg_idx) neg_c = c;
                    if (ix == h_idx)   h_c = c;
                end
                if (s_axis_tlast)
                begin
                    cell_q.push_back(surface_result());
                    ion_acc = 0;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                a = m_axis_tdata;
                results_seen <= results_seen + 1;
                if (cell_q.size() == 0)
                begin
                    $error("result with nothing expected: %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = cell_q.pop_front();
                    if (a.activity !== e.activity)
                        $error("surface_activity: expected %h actual %h",
                               e.activity, a.activity);
                    if (a.factor !== e.factor)
                        $error("factor: expected %h actual %h", e.factor, a.factor);
                    if (a !== e)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end
endmodule

FILE: bench/tb_top.sv
// testbench top for the surface activity block: stimulus, configuration and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gcsa_pkg::*;

    localparam int NCOMP = 16;
    localparam int LAST_LATENCY = 600;     // extra wait in settle() after every result is out
    localparam int IDLE_LIMIT = 20000;     // cycles with no request before giving up

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;             // conc [31:0], comp_index [37:32], zero fill
    logic        s_axis_tlast;             // last component of the cell
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;             // surface_activity [31:0], factor [63:32]
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          idle_cycles;
    int          cells_sent;
    int          comps_sent;
    bit          long_hold;                // sink stalls for a long stretch when set

    gouy_chapman_surface_activity #(.NUM_COMPONENTS(NCOMP)) u_top (.*);

    gcsa_checker #(.NUM_COMPONENTS(NCOMP)) u_check (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // watchdog: counts cycles without any accepted request on either side or register write
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result sink: random stall per request, plus one long hold-off on request
    initial
    begin
        int w;
        m_axis_tready <= 0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge clk);
                long_hold = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (w != 0)
            begin
                m_axis_tready <= 0;
                repeat (w) @(posedge clk);
            end
            m_axis_tready <= 1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // register write once the block is idle and every result has come out
    task automatic write_reg(input cfg_reg_t r, input logic [63:0] v);
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0 || !s_axis_tready)
            @(posedge clk);
        cfg_we <= 1;
        cfg_addr <= r;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // one component request; gap drawn per request unless told not to idle
    task automatic send_comp(input logic [31:0] c, input logic [5:0] ix, input bit lst,
                             input bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 10);
        if (w != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (w) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, ix, c};
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        comps_sent++;
        if (lst)
            cells_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LAST_LATENCY) @(posedge clk);
    endtask

    // concentration with a mix of extremes, small values and full-range noise
    function automatic logic [31:0] rand_conc();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    // cell: components in random order, sometimes only part of them, some noise mixed in
    task automatic send_cell(input bit no_gap);
        logic [5:0] order[$];
        int n;
        for (int i = 0; i < NCOMP; i++)
            order.push_back(6'(i));
        order.shuffle();
        if ($urandom_range(0, 4) == 0)
            n = $urandom_range(1, NCOMP);  // partial cell, some species missing
        else
            n = NCOMP;
        for (int i = 0; i < n; i++)
        begin
            // occasional out-of-range or repeated index
            if ($urandom_range(0, 9) == 0)
                order[i] = $urandom_range(0, 63);
            send_comp(rand_conc(), order[i], i == n - 1, no_gap);
        end
    endtask

    task automatic random_config(input bit extreme);
        write_reg(REG_POS_IDX, $urandom_range(0, 63) % (extreme ? 64 : NCOMP));
        write_reg(REG_NEU_IDX, $urandom_range(0, NCOMP - 1));
        write_reg(REG_NEG_IDX, $urandom_range(0, NCOMP - 1));
        write_reg(REG_PROTON_IDX, $urandom_range(0, NCOMP - 1));
        write_reg(REG_CHARGED_MASK, extreme ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
        write_reg(REG_CHARGE_SCALE, extreme ? 32'hFFFF_FFFF : $urandom);
        write_reg(REG_ION_FLOOR, extreme ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0010_0000));
        write_reg(REG_SITE_EPS, $urandom_range(0, 1) ? 0 : $urandom_range(0, 32'h100));
    endtask

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        cfg_we = 0;
        cfg_addr = 0;
        cfg_data = 0;
        long_hold = 0;
        cells_sent = 0;
        comps_sent = 0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset settings, zero state gives unit factor
        send_comp(0, 0, 1, 0);
        // charged components, positive surface charge
        write_reg(REG_CHARGED_MASK, 64'h0000_0000_0000_FFF0);
        send_comp(32'h0002_0000, 0, 0, 0);
        send_comp(32'h0001_0000, 1, 0, 0);
        send_comp(32'h0000_8000, 2, 0, 0);
        send_comp(32'h0000_1000, 3, 0, 0);
        send_comp(32'h0001_0000, 4, 1, 0);
        // negative surface charge, large scale
        write_reg(REG_CHARGE_SCALE, 32'hFFFF_FFFF);
        send_comp(0, 0, 0, 0);
        send_comp(32'hFFFF_FFFF, 2, 0, 0);
        send_comp(32'hFFFF_FFFF, 3, 0, 0);
        send_comp(1, 5, 1, 0);
        // large ion sum: full mask, maximal values, index beyond range
        write_reg(REG_CHARGED_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_comp(32'hFFFF_FFFF, i[5:0], 0, 1);
        send_comp(32'h1234_5678, 6'd63, 1, 0);
        // zero site total with zero epsilon, and shared indices
        write_reg(REG_POS_IDX, 5);
        write_reg(REG_NEU_IDX, 5);
        write_reg(REG_NEG_IDX, 5);
        write_reg(REG_ION_FLOOR, 32'hFFFF_FFFF);
        send_comp(0, 5, 1, 0);
        write_reg(REG_SITE_EPS, 32'hFFFF_FFFF);
        send_comp(32'h8000_0000, 5, 1, 0);
        settle();

        // random phases with changing settings
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                random_config(1);
            else
                random_config(0);
            if (phase == 3)
                long_hold = 1;  // sink stops while cells keep arriving
            for (int k = 0; k < 11; k++)
                send_cell(phase == 3 || ($urandom_range(0, 3) == 0));
            settle();  // sender waits for every result
        end
        write_reg(REG_CHARGE_SCALE, 0);
        write_reg(REG_ION_FLOOR, 0);
        write_reg(REG_SITE_EPS, 0);
        for (int k = 0; k < 4; k++)
            send_cell(0);
        settle();

        $display("sent %0d components in %0d cells, %0d results checked",
                 comps_sent, cells_sent, results_seen);
        $display("covered extremes, saturation, zero totals, shared and out-of-range indices");
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
